// ===== hdl/token_lexer_stream_assert.svh =====
// assertion macros for the token lexer
`ifndef TOKEN_LEXER_STREAM_ASSERT_SVH
`define TOKEN_LEXER_STREAM_ASSERT_SVH
`ifndef SYNTH
`define TLS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("token lexer assertion failed");
`define TLS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("token lexer assertion failed");
`define TLS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("token lexer assertion failed");
`else
`define TLS_ASSERT(lbl, clk, rst, prop)
`define TLS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TLS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/tls_pkg.sv =====
`default_nettype none

package tls_pkg;

   localparam int unsigned DEF_TOKEN_LENGTH_LIMIT = 255;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_text;
   } req_word_type;

   typedef struct packed {
      logic [4:0] token_class;
      logic [7:0] token_length;
      logic [2:0] error_code;
      logic       last_of_run;
   } rsp_word_type;

   // token classes, keywords are 0 to 7
   localparam logic [4:0] CLS_AO        = 5'd8;
   localparam logic [4:0] CLS_RO        = 5'd9;
   localparam logic [4:0] CLS_LO        = 5'd10;
   localparam logic [4:0] CLS_PLUS      = 5'd11;
   localparam logic [4:0] CLS_MINUS     = 5'd12;
   localparam logic [4:0] CLS_TIMES     = 5'd13;
   localparam logic [4:0] CLS_DIVISION  = 5'd14;
   localparam logic [4:0] CLS_COMMA     = 5'd15;
   localparam logic [4:0] CLS_BRACE     = 5'd16;
   localparam logic [4:0] CLS_SEMICOLON = 5'd17;
   localparam logic [4:0] CLS_INT       = 5'd18;
   localparam logic [4:0] CLS_DOUBLE    = 5'd19;
   localparam logic [4:0] CLS_IDENT     = 5'd20;
   localparam logic [4:0] CLS_ERROR     = 5'd21;
   localparam logic [4:0] CLS_END       = 5'd22;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_UNREC     = 3'd1;
   localparam logic [2:0] ERR_DOT_EDGE  = 3'd2;
   localparam logic [2:0] ERR_LEAD_ZERO = 3'd3;
   localparam logic [2:0] ERR_MULTI_DOT = 3'd4;

   localparam int unsigned KW_COUNT = 8;

   // keyword text, first character in the top byte
   localparam logic [0:KW_COUNT-1][47:0] KW_TEXT = '{
      {"int", 24'h0}, {"double"}, {"scanf", 8'h0}, {"printf"},
      {"if", 32'h0}, {"then", 16'h0}, {"while", 8'h0}, {"do", 32'h0}
   };

   localparam logic [0:KW_COUNT-1][2:0] KW_LEN = '{
      3'd3, 3'd6, 3'd5, 3'd6, 3'd2, 3'd4, 3'd5, 3'd2
   };

   function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] p);
      logic [5:0] hi;
      hi = 6'd47 - {p, 3'b000};
      return KW_TEXT[k][hi -: 8];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/token_lexer_stream.sv =====
// token_lexer_stream: lexical analyzer for a small C-like language
//
// req channel: one source character per word (char_code, end_of_text).
// rsp channel: classified tokens, one token per word; last_of_run marks the
// final token that a character caused. A character causes zero to three
// tokens.
// a character is registered on acceptance and classified from the input register;
// the three-entry result buffer loads all of its tokens at once when it has room,
// and the first token is on rsp in the cycle after that load.
// throughput: one character per cycle while each causes at most one token and
// rsp does not stall; a character with k tokens holds the rsp port while the
// result buffer drains them, one token per cycle while rsp does not stall.
// a stall on rsp holds the current token; the input register then fills and
// req_stall rises until the buffer has room.
// an error token halts the lexer; later characters are taken and dropped
// until reset. after the end token the lexer starts over on a new text.
// reset clears the lexer state, the input register and the result buffer.
`default_nettype none
`include "token_lexer_stream_assert.svh"

module token_lexer_stream #(
   parameter int unsigned TOKEN_LENGTH_LIMIT = tls_pkg::DEF_TOKEN_LENGTH_LIMIT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire tls_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output tls_pkg::rsp_word_type      rsp_word
);
   import tls_pkg::*;

   localparam int unsigned CNT_W = $clog2(TOKEN_LENGTH_LIMIT + 1);

   typedef enum logic [2:0] {
      MODE_BEGIN,
      MODE_WORD,
      MODE_NUMBER,
      MODE_CMP,
      MODE_PAIR
   } mode_type;

   typedef struct packed {
      mode_type         mode;
      logic [7:0]       op;
      logic [7:0]       cand;
      logic [CNT_W-1:0] cnt;
      logic [1:0]       dots;
      logic [3:0]       flags;
   } lex_state_type;

   typedef struct packed {
      logic       active;
      logic       is_err;
      logic [4:0] cls;
      logic [7:0] len;
      logic [2:0] err;
   } fin_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A;
   endfunction

   function automatic logic is_single(input logic [7:0] c);
      return c == "+" || c == "-" || c == "*" || c == "/" || c == "," || c == "(" ||
         c == ")" || c == "{" || c == "}" || c == ";";
   endfunction

   function automatic logic [4:0] single_class(input logic [7:0] c);
      logic [4:0] cls;
      unique case (c)
         "+": cls = CLS_PLUS;
         "-": cls = CLS_MINUS;
         "*": cls = CLS_TIMES;
         "/": cls = CLS_DIVISION;
         ",": cls = CLS_COMMA;
         ";": cls = CLS_SEMICOLON;
         "(", ")", "{", "}": cls = CLS_BRACE;
         default: cls = CLS_IDENT;
      endcase
      return cls;
   endfunction

   function automatic logic [7:0] sat_len(input logic [CNT_W-1:0] cnt);
      logic [15:0] wide;
      wide = 16'(cnt);
      return (wide > 16'd255) ? 8'hFF : wide[7:0];
   endfunction

   function automatic lex_state_type lex_clear();
      lex_state_type s;
      s.mode  = MODE_BEGIN;
      s.op    = 8'h00;
      s.cand  = 8'hFF;
      s.cnt   = '0;
      s.dots  = 2'd0;
      s.flags = 4'd0;
      return s;
   endfunction

   function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] cnt);
      return (cnt < CNT_W'(TOKEN_LENGTH_LIMIT)) ? cnt + CNT_W'(1) : cnt;
   endfunction

   function automatic lex_state_type word_step(input lex_state_type st, input logic [7:0] c);
      lex_state_type s;
      s = st;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (s.cnt >= CNT_W'(KW_LEN[k]) || kw_char(3'(k), s.cnt[2:0]) != c) begin
            s.cand[k] = 1'b0;
         end
      end
      s.cnt = count_up(s.cnt);
      return s;
   endfunction

   function automatic lex_state_type number_step(input lex_state_type st, input logic [7:0] c);
      lex_state_type s;
      s = st;
      if (s.cnt == CNT_W'(1) && c != ".") begin
         s.flags[3] = 1'b1;
      end
      if (c == ".") begin
         s.flags[2] = 1'b1;
         if (s.dots != 2'd2) begin
            s.dots = s.dots + 2'd1;
         end
      end else begin
         s.flags[2] = 1'b0;
      end
      s.cnt = count_up(s.cnt);
      return s;
   endfunction

   function automatic fin_type finish_calc(input lex_state_type s);
      fin_type f;
      f.active = 1'b1;
      f.cls    = CLS_IDENT;
      f.len    = sat_len(s.cnt);
      f.err    = ERR_NONE;
      unique case (s.mode)
         MODE_CMP: begin
            f.cls = (s.op == "=") ? CLS_AO : ((s.op == "!") ? CLS_LO : CLS_RO);
            f.len = 8'd1;
         end
         MODE_PAIR: begin
            f.len = 8'd1;
         end
         MODE_WORD: begin
            for (int k = 0; k < KW_COUNT; k++) begin
               if (s.cand[k] && s.cnt == CNT_W'(KW_LEN[k])) begin
                  f.cls = 5'(k);
               end
            end
         end
         MODE_NUMBER: begin
            if (s.flags[1]) begin
               f.err = ERR_DOT_EDGE;
            end else if (s.dots == 2'd0) begin
               f.err = (s.flags[0] && s.cnt != CNT_W'(1)) ? ERR_LEAD_ZERO : ERR_NONE;
            end else if (s.dots == 2'd1) begin
               f.err = (s.flags[0] && s.flags[3]) ? ERR_LEAD_ZERO :
                  (s.flags[2] ? ERR_DOT_EDGE : ERR_NONE);
            end else begin
               f.err = ERR_MULTI_DOT;
            end
            f.cls = (s.dots == 2'd0) ? CLS_INT : CLS_DOUBLE;
         end
         default: begin
            f.active = 1'b0;
         end
      endcase
      f.is_err = f.err != ERR_NONE;
      return f;
   endfunction

   function automatic rsp_word_type make_rsp(input logic [4:0] cls, input logic [7:0] len,
                                             input logic [2:0] err);
      rsp_word_type r;
      r.token_class  = cls;
      r.token_length = len;
      r.error_code   = err;
      r.last_of_run  = 1'b0;
      return r;
   endfunction

   logic          in_valid_ff;
   logic          in_valid_in;
   req_word_type  in_word_ff;
   lex_state_type lex_ff;
   lex_state_type lex_in;
   logic          halted_ff;
   logic          halted_in;
   rsp_word_type  res_ff [0:2];
   rsp_word_type  res_in [0:2];
   logic [1:0]    left_ff;
   logic [1:0]    ptr_ff;
   logic [1:0]    n_res;
   logic          take;
   logic          buf_free;
   logic          advance;
   logic          req_accept;
   logic          consumed;
   logic [7:0]    c;
   fin_type       fin_a;
   fin_type       fin_b;

   assign rsp_valid  = left_ff != 2'd0;
   assign rsp_word   = res_ff[ptr_ff];
   assign take       = rsp_valid && !rsp_stall;
   assign buf_free   = (left_ff == 2'd0) || (left_ff == 2'd1 && take);
   assign advance    = in_valid_ff && buf_free;
   assign req_stall  = in_valid_ff && !buf_free;
   assign req_accept = req_valid && !req_stall;
   assign in_valid_in = req_accept || (in_valid_ff && !advance);

   // classify one character against the lexer state
   always_comb begin
      c         = in_word_ff.char_code;
      lex_in    = lex_ff;
      halted_in = halted_ff;
      res_in    = res_ff;
      n_res     = 2'd0;
      consumed  = 1'b0;
      fin_a     = '0;
      fin_b     = '0;
      if (!halted_ff) begin
         unique case (lex_ff.mode)
            MODE_CMP: begin
               if (c == "=") begin
                  res_in[n_res] = make_rsp(CLS_RO, 8'd2, ERR_NONE);
                  n_res = n_res + 2'd1;
                  lex_in = lex_clear();
                  consumed = 1'b1;
               end
            end
            MODE_PAIR: begin
               if (c == lex_ff.op) begin
                  res_in[n_res] = make_rsp(CLS_LO, 8'd2, ERR_NONE);
                  n_res = n_res + 2'd1;
                  lex_in = lex_clear();
                  consumed = 1'b1;
               end
            end
            MODE_WORD: begin
               if (is_letter(c) || is_digit(c)) begin
                  lex_in = word_step(lex_ff, c);
                  consumed = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (is_digit(c) || c == ".") begin
                  lex_in = number_step(lex_ff, c);
                  consumed = 1'b1;
               end
            end
            default: begin
            end
         endcase

         if (!consumed) begin
            fin_a = finish_calc(lex_in);
            if (fin_a.active) begin
               res_in[n_res] = make_rsp(fin_a.is_err ? CLS_ERROR : fin_a.cls, fin_a.len,
                                        fin_a.err);
               n_res = n_res + 2'd1;
               if (fin_a.is_err) begin
                  halted_in = 1'b1;
               end else begin
                  lex_in = lex_clear();
               end
            end
            if (!halted_in) begin
               priority if (is_space(c)) begin
               end else if (is_letter(c)) begin
                  lex_in.mode = MODE_WORD;
                  lex_in = word_step(lex_in, c);
               end else if (is_digit(c) || c == ".") begin
                  lex_in.mode = MODE_NUMBER;
                  lex_in.flags = (c == "0") ? 4'd1 : ((c == ".") ? 4'd2 : 4'd0);
                  lex_in = number_step(lex_in, c);
               end else if (c == ">" || c == "<" || c == "!" || c == "=") begin
                  lex_in.mode = MODE_CMP;
                  lex_in.op = c;
               end else if (c == "&" || c == "|") begin
                  lex_in.mode = MODE_PAIR;
                  lex_in.op = c;
               end else if (is_single(c)) begin
                  res_in[n_res] = make_rsp(single_class(c), 8'd1, ERR_NONE);
                  n_res = n_res + 2'd1;
               end else begin
                  res_in[n_res] = make_rsp(CLS_ERROR, 8'd1, ERR_UNREC);
                  n_res = n_res + 2'd1;
                  halted_in = 1'b1;
               end
            end
         end

         if (!halted_in && in_word_ff.end_of_text) begin
            fin_b = finish_calc(lex_in);
            if (fin_b.active) begin
               res_in[n_res] = make_rsp(fin_b.is_err ? CLS_ERROR : fin_b.cls, fin_b.len,
                                        fin_b.err);
               n_res = n_res + 2'd1;
               if (fin_b.is_err) begin
                  halted_in = 1'b1;
               end
            end
            if (!halted_in) begin
               res_in[n_res] = make_rsp(CLS_END, 8'd0, ERR_NONE);
               n_res = n_res + 2'd1;
               lex_in = lex_clear();
            end
         end

         if (n_res != 2'd0) begin
            res_in[n_res - 2'd1].last_of_run = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         lex_ff      <= lex_clear();
         halted_ff   <= 1'b0;
         left_ff     <= 2'd0;
         ptr_ff      <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            lex_ff    <= lex_in;
            halted_ff <= halted_in;
            left_ff   <= n_res;
            ptr_ff    <= 2'd0;
         end else if (take) begin
            left_ff <= left_ff - 2'd1;
            ptr_ff  <= ptr_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         res_ff <= res_in;
      end
   end

   `TLS_ASSERT_IMP(a_error_halts, clock, reset,
      rsp_valid && rsp_word.token_class == CLS_ERROR, halted_ff)
   `TLS_ASSERT_IMP(a_err_code_only_on_error, clock, reset,
      rsp_valid && rsp_word.error_code != ERR_NONE, rsp_word.token_class == CLS_ERROR)
   `TLS_ASSERT_IMP(a_last_matches_buffer, clock, reset,
      rsp_valid, rsp_word.last_of_run == (left_ff == 2'd1))
   `TLS_ASSERT_NEXT(a_halted_is_silent, clock, reset,
      advance && halted_ff, left_ff == 2'd0)

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none

module tb_top;
   import tls_pkg::*;

   localparam int unsigned HOLD_CYCLES = 80;
   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned TAIL_CYCLES = 12;
   localparam int unsigned PHASE_CHARS = 20;
   localparam logic [4:0]  NO_CLASS    = 5'd31;

   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_WORD, SCAN_NUMBER, SCAN_CMP, SCAN_PAIR
   } scan_mode_type;

   typedef logic [7:0] text_type[$];

   class token_scoreboard_type;
      scan_mode_type mode;
      logic [7:0]    held_op;
      logic [7:0]    kw_alive;
      int unsigned   run_len;
      int unsigned   dots;
      logic [3:0]    nflags;
      bit            stopped;
      rsp_word_type  due[$];
      rsp_word_type  batch[$];
      int unsigned   fails;

      function new();
         fails = 0;
         stopped = 1'b0;
         restart_token();
      endfunction

      static function bit is_letter(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
      endfunction

      static function bit is_digit(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      static function bit is_space(logic [7:0] c);
         return c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a;
      endfunction

      static function logic [4:0] single_cls(logic [7:0] c);
         case (c)
            "+": return CLS_PLUS;
            "-": return CLS_MINUS;
            "*": return CLS_TIMES;
            "/": return CLS_DIVISION;
            ",": return CLS_COMMA;
            "(", ")", "{", "}": return CLS_BRACE;
            ";": return CLS_SEMICOLON;
            default: return NO_CLASS;
         endcase
      endfunction

      static function bit known_char(logic [7:0] c);
         return is_letter(c) || is_digit(c) || is_space(c) || c == "." || c == ">" ||
                c == "<" || c == "!" || c == "=" || c == "&" || c == "|" ||
                single_cls(c) != NO_CLASS;
      endfunction

      function void restart_token();
         mode = SCAN_IDLE;
         held_op = 8'h00;
         kw_alive = 8'hff;
         run_len = 0;
         dots = 0;
         nflags = 4'h0;
      endfunction

      function void push_token(logic [4:0] cls, int unsigned len, logic [2:0] err);
         rsp_word_type t;
         if (batch.size() >= 3) return;
         t.token_class = cls;
         t.token_length = (len > 255) ? 8'd255 : 8'(len);
         t.error_code = err;
         t.last_of_run = 1'b0;
         batch = {batch, t};
      endfunction

      function void add_len();
         if (run_len < DEF_TOKEN_LENGTH_LIMIT) run_len++;
      endfunction

      function void word_step(logic [7:0] c);
         logic [47:0] txt;
         for (int k = 0; k < KW_COUNT; k++) begin
            txt = KW_TEXT[k];
            if (run_len >= KW_LEN[k]) kw_alive[k] = 1'b0;
            else if (txt[47 - 8*run_len -: 8] != c) kw_alive[k] = 1'b0;
         end
         add_len();
      endfunction

      function void number_step(logic [7:0] c);
         if (run_len == 1 && c != ".") nflags[3] = 1'b1;
         if (c == ".") begin
            nflags[2] = 1'b1;
            if (dots < 2) dots++;
         end else begin
            nflags[2] = 1'b0;
         end
         add_len();
      endfunction

      // returns 0 when the token is malformed and the lexer stops
      function bit close_token();
         int unsigned len;
         logic [4:0]  cls;
         logic [2:0]  err;
         len = run_len;
         cls = CLS_IDENT;
         err = ERR_NONE;
         case (mode)
            SCAN_CMP: begin
               cls = (held_op == "=") ? CLS_AO : ((held_op == "!") ? CLS_LO : CLS_RO);
               len = 1;
            end
            SCAN_PAIR: begin
               len = 1;
            end
            SCAN_WORD: begin
               for (int k = 0; k < KW_COUNT; k++)
                  if (kw_alive[k] && run_len == KW_LEN[k]) cls = 5'(k);
            end
            SCAN_NUMBER: begin
               if (nflags[1]) err = ERR_DOT_EDGE;
               else if (dots == 0)
                  err = (nflags[0] && run_len != 1) ? ERR_LEAD_ZERO : ERR_NONE;
               else if (dots == 1)
                  err = (nflags[0] && nflags[3]) ? ERR_LEAD_ZERO :
                        (nflags[2] ? ERR_DOT_EDGE : ERR_NONE);
               else err = ERR_MULTI_DOT;
               cls = (dots == 0) ? CLS_INT : CLS_DOUBLE;
            end
            default: return 1'b1;
         endcase
         if (err != ERR_NONE) begin
            push_token(CLS_ERROR, len, err);
            stopped = 1'b1;
            return 1'b0;
         end
         push_token(cls, len, ERR_NONE);
         restart_token();
         return 1'b1;
      endfunction

      function void open_token(logic [7:0] c);
         logic [4:0] cls;
         if (is_space(c)) return;
         if (is_letter(c)) begin
            mode = SCAN_WORD;
            word_step(c);
         end else if (is_digit(c) || c == ".") begin
            mode = SCAN_NUMBER;
            nflags = (c == "0") ? 4'h1 : ((c == ".") ? 4'h2 : 4'h0);
            number_step(c);
         end else if (c == ">" || c == "<" || c == "!" || c == "=") begin
            mode = SCAN_CMP;
            held_op = c;
         end else if (c == "&" || c == "|") begin
            mode = SCAN_PAIR;
            held_op = c;
         end else begin
            cls = single_cls(c);
            if (cls != NO_CLASS) begin
               push_token(cls, 1, ERR_NONE);
            end else begin
               push_token(CLS_ERROR, 1, ERR_UNREC);
               stopped = 1'b1;
            end
         end
      endfunction

      function void note_req(req_word_type w);
         logic [7:0]   c;
         bit           taken;
         c = w.char_code;
         taken = 1'b0;
         batch.delete();
         if (stopped) return;
         case (mode)
            SCAN_CMP: if (c == "=") begin
               push_token(CLS_RO, 2, ERR_NONE);
               restart_token();
               taken = 1'b1;
            end
            SCAN_PAIR: if (c == held_op) begin
               push_token(CLS_LO, 2, ERR_NONE);
               restart_token();
               taken = 1'b1;
            end
            SCAN_WORD: if (is_letter(c) || is_digit(c)) begin
               word_step(c);
               taken = 1'b1;
            end
            SCAN_NUMBER: if (is_digit(c) || c == ".") begin
               number_step(c);
               taken = 1'b1;
            end
            default: ;
         endcase
         if (!taken && close_token()) open_token(c);
         if (!stopped && w.end_of_text) begin
            if (close_token()) begin
               push_token(CLS_END, 0, ERR_NONE);
               restart_token();
            end
         end
         if (batch.size() > 0) batch[batch.size() - 1].last_of_run = 1'b1;
         foreach (batch[i]) due = {due, batch[i]};
      endfunction

      function void check_rsp(rsp_word_type got);
         rsp_word_type want;
         if (due.size() == 0) begin
            $error("token word with nothing expected: class %0d length %0d error %0d",
                   got.token_class, got.token_length, got.error_code);
            fails++;
            return;
         end
         want = due.pop_front();
         if (got.token_class !== want.token_class) begin
            $error("token_class: expected %0d, actual %0d", want.token_class, got.token_class);
            fails++;
         end
         if (got.token_length !== want.token_length) begin
            $error("token_length: expected %0d, actual %0d",
                   want.token_length, got.token_length);
            fails++;
         end
         if (got.error_code !== want.error_code) begin
            $error("error_code: expected %0d, actual %0d", want.error_code, got.error_code);
            fails++;
         end
         if (got.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d, actual %0d", want.last_of_run, got.last_of_run);
            fails++;
         end
      endfunction

      function int unsigned outstanding();
         return due.size();
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   token_scoreboard_type board = new();

   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   bit          long_hold = 1'b0;
   int unsigned chars_sent = 0;
   int unsigned quiet_cycles = 0;

   string keywords[8] = '{"int", "double", "scanf", "printf", "if", "then", "while", "do"};
   string singles = "+-*/,(){};";
   string compares = "<>!=";
   logic [7:0] blanks[4] = '{8'h20, 8'h09, 8'h0d, 8'h0a};

   token_lexer_stream dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_req(req_word);
         if (rsp_valid && !rsp_stall) board.check_rsp(rsp_word);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // receiver side
   initial begin
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            long_hold = 1'b0;
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   task automatic send_char(logic [7:0] c, bit eot);
      req_word_type w;
      w.char_code = c;
      w.end_of_text = eot;
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      chars_sent++;
   endtask

   task automatic send_text(text_type txt);
      foreach (txt[i]) send_char(txt[i], i == txt.size() - 1);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(negedge clock);
   endtask

   function automatic void add_char(ref text_type txt, input logic [7:0] c);
      txt = {txt, c};
   endfunction

   function automatic logic [7:0] rand_letter();
      int unsigned r;
      r = $urandom_range(0, 52);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      return "_";
   endfunction

   function automatic logic [7:0] rand_digit(int unsigned lo);
      return 8'("0" + $urandom_range(lo, 9));
   endfunction

   function automatic logic [7:0] rand_alnum();
      return ($urandom_range(0, 4) == 0) ? rand_digit(0) : rand_letter();
   endfunction

   function automatic void add_blanks(ref text_type txt);
      int unsigned n;
      n = $urandom_range(1, 2);
      repeat (n) add_char(txt, blanks[$urandom_range(0, 3)]);
   endfunction

   function automatic void add_int_part(ref text_type txt);
      int unsigned n;
      if ($urandom_range(0, 3) == 0) begin
         add_char(txt, "0");
      end else begin
         add_char(txt, rand_digit(1));
         n = $urandom_range(0, 4);
         repeat (n) add_char(txt, rand_digit(0));
      end
   endfunction

   function automatic void add_long(ref text_type txt, input bit numeric);
      int unsigned n;
      n = $urandom_range(256, 260);
      add_char(txt, numeric ? rand_digit(1) : rand_letter());
      repeat (n - 1) add_char(txt, numeric ? rand_digit(0) : rand_alnum());
   endfunction

   // numbers are kept apart from a preceding word or number
   function automatic void add_token(ref text_type txt, ref bit alnum_last);
      int unsigned kind, k, n;
      string       kw;
      kind = $urandom_range(0, 7);
      if ((alnum_last && (kind == 2 || kind == 3)) || $urandom_range(0, 1) == 1)
         add_blanks(txt);
      case (kind)
         0, 7: begin
            kw = keywords[$urandom_range(0, 7)];
            k = (kind == 0) ? $urandom_range(0, 3) : 3;
            if (k == 1) kw = kw.substr(0, kw.len() - 2);
            if (k == 2) kw[0] = 8'(kw[0] - 8'd32);
            for (int i = 0; i < kw.len(); i++) add_char(txt, kw[i]);
            if (k == 0) add_char(txt, rand_alnum());
         end
         1: begin
            n = $urandom_range(1, 8);
            add_char(txt, rand_letter());
            repeat (n - 1) add_char(txt, rand_alnum());
         end
         2: add_int_part(txt);
         3: begin
            add_int_part(txt);
            add_char(txt, ".");
            n = $urandom_range(1, 3);
            repeat (n) add_char(txt, rand_digit(0));
         end
         4: add_char(txt, singles[$urandom_range(0, 9)]);
         5: begin
            add_char(txt, compares[$urandom_range(0, 3)]);
            if ($urandom_range(0, 1) == 1) add_char(txt, "=");
         end
         default: begin
            add_char(txt, $urandom_range(0, 1) ? "&" : "|");
            if ($urandom_range(0, 1) == 1) add_char(txt, txt[txt.size() - 1]);
         end
      endcase
      alnum_last = (kind <= 3 || kind == 7);
   endfunction

   function automatic void build_text(ref text_type txt);
      bit          alnum_last;
      int unsigned n;
      txt.delete();
      alnum_last = 1'b0;
      n = $urandom_range(1, 10);
      repeat (n) add_token(txt, alnum_last);
      if ($urandom_range(0, 1) == 1) add_blanks(txt);
   endfunction

   // malformed token that halts the lexer
   function automatic void add_fault(ref text_type txt);
      logic [7:0] c;
      add_char(txt, 8'h20);
      case ($urandom_range(1, 4))
         1: begin
            do c = 8'($urandom_range(0, 255)); while (token_scoreboard_type::known_char(c));
            add_char(txt, c);
         end
         2: begin
            if ($urandom_range(0, 1) == 1) begin
               add_char(txt, ".");
               add_char(txt, rand_digit(0));
            end else begin
               add_char(txt, rand_digit(1));
               add_char(txt, ".");
            end
         end
         3: begin
            add_char(txt, "0");
            if ($urandom_range(0, 1) == 1) add_char(txt, "0");
            add_char(txt, rand_digit(1));
            if ($urandom_range(0, 1) == 1) begin
               add_char(txt, ".");
               add_char(txt, rand_digit(0));
            end
         end
         default: begin
            add_char(txt, rand_digit(1));
            add_char(txt, ".");
            add_char(txt, rand_digit(0));
            add_char(txt, ".");
            add_char(txt, rand_digit(0));
         end
      endcase
      add_char(txt, 8'h20);
      add_char(txt, ";");
   endfunction

   initial begin
      text_type    txt;
      string       directed;
      int unsigned mark;
      bit          alnum_last;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // operators alone and paired, all single classes, numbers, three tokens on the last
      directed = "a>=b<c!d=e&&f|g+-*/,(){}0 7.5 x;";
      txt.delete();
      for (int i = 0; i < directed.len(); i++) add_char(txt, directed[i]);
      send_text(txt);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 58; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 58; end
            default: begin idle_pct = 17; stall_pct = 17; end
         endcase
         if (ph == 0) long_hold = 1'b1;
         mark = chars_sent;
         // one token past the length limit
         if (ph == 1) begin
            txt.delete();
            add_long(txt, $urandom_range(0, 1) == 1);
            send_text(txt);
         end
         while (chars_sent - mark < PHASE_CHARS) begin
            build_text(txt);
            send_text(txt);
         end
         drain();
      end

      // one malformed text, then everything after it must be dropped
      idle_pct = 17;
      stall_pct = 17;
      txt.delete();
      alnum_last = 1'b0;
      repeat ($urandom_range(0, 3)) add_token(txt, alnum_last);
      add_fault(txt);
      send_text(txt);
      repeat (20) send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.fails == 0 && board.outstanding() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
